// ===== sv/assert_macros.svh =====
// Assertion macros shared by the keyboard matrix RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define AKM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that one condition implies another on the following edge.
`define AKM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/akm_pkg.sv =====
// Shared types, constants and the character table of the keyboard matrix.
`timescale 1ns / 1ps

package akm_pkg;

   localparam int unsigned NUM_ROWS  = 16;
   localparam int unsigned ROW_BITS  = 4;
   localparam int unsigned COL_BITS  = 3;
   localparam int unsigned ROW_WIDTH = 8;

   localparam logic [ROW_BITS-1:0]  SHIFT_ROW = 4'd6;
   localparam logic [COL_BITS-1:0]  SHIFT_COL = 3'd0;
   localparam logic [ROW_BITS-1:0]  SPACE_ROW = 4'd8;
   localparam logic [COL_BITS-1:0]  SPACE_COL = 3'd0;
   localparam logic [ROW_WIDTH-1:0] ROW_IDLE  = 8'hFF;

   localparam logic [7:0] UPPER_FIRST = 8'd65;
   localparam logic [7:0] UPPER_LAST  = 8'd90;
   localparam logic [6:0] CASE_BIT    = 7'h20;

   typedef enum logic [1:0] {
      OP_SELECT = 2'd0,
      OP_READ   = 2'd1,
      OP_EVENT  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef logic [ROW_WIDTH-1:0] row_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                shift;
   } key_loc_type;

   function automatic key_loc_type key_at(logic [ROW_BITS-1:0] row,
                                          logic [COL_BITS-1:0] col,
                                          logic shift);
      key_loc_type loc;
      loc.row   = row;
      loc.col   = col;
      loc.shift = shift;
      return loc;
   endfunction

   // Position of a 7-bit character; unlisted codes land on space.
   function automatic key_loc_type char_map(logic [6:0] ch);
      key_loc_type loc;
      unique case (ch)
         7'h37: loc = key_at(4'd0, 3'd7, 1'b0);
         7'h26: loc = key_at(4'd0, 3'd7, 1'b1);
         7'h36: loc = key_at(4'd0, 3'd6, 1'b0);
         7'h5E: loc = key_at(4'd0, 3'd6, 1'b1);
         7'h35: loc = key_at(4'd0, 3'd5, 1'b0);
         7'h25: loc = key_at(4'd0, 3'd5, 1'b1);
         7'h34: loc = key_at(4'd0, 3'd4, 1'b0);
         7'h24: loc = key_at(4'd0, 3'd4, 1'b1);
         7'h33: loc = key_at(4'd0, 3'd3, 1'b0);
         7'h23: loc = key_at(4'd0, 3'd3, 1'b1);
         7'h32: loc = key_at(4'd0, 3'd2, 1'b0);
         7'h40: loc = key_at(4'd0, 3'd2, 1'b1);
         7'h31: loc = key_at(4'd0, 3'd1, 1'b0);
         7'h21: loc = key_at(4'd0, 3'd1, 1'b1);
         7'h30: loc = key_at(4'd0, 3'd0, 1'b0);
         7'h29: loc = key_at(4'd0, 3'd0, 1'b1);
         7'h3B: loc = key_at(4'd1, 3'd7, 1'b0);
         7'h3A: loc = key_at(4'd1, 3'd7, 1'b1);
         7'h5C: loc = key_at(4'd1, 3'd4, 1'b0);
         7'h7C: loc = key_at(4'd1, 3'd4, 1'b1);
         7'h3D: loc = key_at(4'd1, 3'd3, 1'b0);
         7'h2B: loc = key_at(4'd1, 3'd3, 1'b1);
         7'h2D: loc = key_at(4'd1, 3'd2, 1'b0);
         7'h5F: loc = key_at(4'd1, 3'd2, 1'b1);
         7'h39: loc = key_at(4'd1, 3'd1, 1'b0);
         7'h28: loc = key_at(4'd1, 3'd1, 1'b1);
         7'h38: loc = key_at(4'd1, 3'd0, 1'b0);
         7'h2A: loc = key_at(4'd1, 3'd0, 1'b1);
         7'h62: loc = key_at(4'd2, 3'd7, 1'b0);
         7'h61: loc = key_at(4'd2, 3'd6, 1'b0);
         7'h2F: loc = key_at(4'd2, 3'd4, 1'b0);
         7'h3F: loc = key_at(4'd2, 3'd4, 1'b1);
         7'h2E: loc = key_at(4'd2, 3'd3, 1'b0);
         7'h3E: loc = key_at(4'd2, 3'd3, 1'b1);
         7'h2C: loc = key_at(4'd2, 3'd2, 1'b0);
         7'h3C: loc = key_at(4'd2, 3'd2, 1'b1);
         7'h60: loc = key_at(4'd2, 3'd1, 1'b0);
         7'h7E: loc = key_at(4'd2, 3'd1, 1'b1);
         7'h27: loc = key_at(4'd2, 3'd0, 1'b0);
         7'h22: loc = key_at(4'd2, 3'd0, 1'b1);
         7'h6A: loc = key_at(4'd3, 3'd7, 1'b0);
         7'h69: loc = key_at(4'd3, 3'd6, 1'b0);
         7'h68: loc = key_at(4'd3, 3'd5, 1'b0);
         7'h67: loc = key_at(4'd3, 3'd4, 1'b0);
         7'h66: loc = key_at(4'd3, 3'd3, 1'b0);
         7'h65: loc = key_at(4'd3, 3'd2, 1'b0);
         7'h64: loc = key_at(4'd3, 3'd1, 1'b0);
         7'h63: loc = key_at(4'd3, 3'd0, 1'b0);
         7'h72: loc = key_at(4'd4, 3'd7, 1'b0);
         7'h71: loc = key_at(4'd4, 3'd6, 1'b0);
         7'h70: loc = key_at(4'd4, 3'd5, 1'b0);
         7'h6F: loc = key_at(4'd4, 3'd4, 1'b0);
         7'h6E: loc = key_at(4'd4, 3'd3, 1'b0);
         7'h6D: loc = key_at(4'd4, 3'd2, 1'b0);
         7'h6C: loc = key_at(4'd4, 3'd1, 1'b0);
         7'h6B: loc = key_at(4'd4, 3'd0, 1'b0);
         7'h7A: loc = key_at(4'd5, 3'd7, 1'b0);
         7'h79: loc = key_at(4'd5, 3'd6, 1'b0);
         7'h78: loc = key_at(4'd5, 3'd5, 1'b0);
         7'h77: loc = key_at(4'd5, 3'd4, 1'b0);
         7'h76: loc = key_at(4'd5, 3'd3, 1'b0);
         7'h75: loc = key_at(4'd5, 3'd2, 1'b0);
         7'h74: loc = key_at(4'd5, 3'd1, 1'b0);
         7'h73: loc = key_at(4'd5, 3'd0, 1'b0);
         7'h0A: loc = key_at(4'd7, 3'd7, 1'b0);
         7'h09: loc = key_at(4'd7, 3'd3, 1'b0);
         default: loc = key_at(SPACE_ROW, SPACE_COL, 1'b0);
      endcase
      return loc;
   endfunction

endpackage

// ===== sv/akm_key_decode.sv =====
// Maps an ASCII byte to its matrix row, column and shift need.
`timescale 1ns / 1ps

module akm_key_decode
   import akm_pkg::*;
(
   input  logic [7:0]  value,
   output key_loc_type loc
);

   logic       upper;
   logic [6:0] folded;
   key_loc_type mapped;

   assign upper  = (value >= UPPER_FIRST) && (value <= UPPER_LAST);
   // fold capitals onto the lower-case entries
   assign folded = upper ? (value[6:0] | CASE_BIT) : value[6:0];
   assign mapped = char_map(folded);

   always_comb begin
      if (value[7]) begin
         loc = key_at(SPACE_ROW, SPACE_COL, 1'b0);
      end else begin
         loc       = mapped;
         loc.shift = mapped.shift | upper;
      end
   end

endmodule

// ===== sv/ascii_keyboard_matrix_top.sv =====
// Top level of the ASCII keyboard matrix: request register, matrix and response register.
`timescale 1ns / 1ps
// Keeps a 16-row by 8-column active-low key matrix and a selected row.
// Request channel (req_valid / req_stall): one word per item carrying
// req_operation, req_value and req_key_down. Operations: select row (low
// four bits of value), read selected row, ASCII key event (press or
// release, with shift for capitals and shifted symbols), and a no-op code.
// Response channel (rsp_valid / rsp_stall): one word, rsp_row_data, for
// each read and nothing for the other operations.
// Throughput: one request per cycle while req_stall is low. A request lands
// in the input register on acceptance and is executed from there by the single
// table lookup and row update once it can advance; a read response passes
// through the input register and then the response register, which shows it.
// A stalled response holds in the response register; the input register
// keeps taking requests until a second read waits behind it, then
// req_stall rises. Non-read requests keep flowing past a stalled response.
// Reset (synchronous, active high) releases every key, selects row 0 and
// empties both registers.

module ascii_keyboard_matrix_top
   import akm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_value,
   input  logic       req_key_down,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_row_data
);

`include "assert_macros.svh"

   logic                s1_valid_ff, s1_valid_in;
   op_type              s1_op_ff;
   logic [7:0]          s1_value_ff;
   logic                s1_key_down_ff;
   logic                req_accept;
   logic                s1_advance;
   logic                out_free;

   row_type             key_matrix_ff [NUM_ROWS];
   row_type             key_matrix_in [NUM_ROWS];
   logic [ROW_BITS-1:0] sel_row_ff, sel_row_in;
   row_type             cur_row;

   logic                rsp_valid_ff, rsp_valid_in;
   row_type             rsp_row_data_ff, rsp_row_data_in;

   logic                do_select, do_read, do_event;
   key_loc_type         loc;

   akm_key_decode u_decode (
      .value (s1_value_ff),
      .loc   (loc)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && ((s1_op_ff != OP_READ) || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);

   always_comb begin
      do_select = 1'b0;
      do_read   = 1'b0;
      do_event  = 1'b0;
      unique case (s1_op_ff)
         OP_SELECT: do_select = s1_advance;
         OP_READ:   do_read   = s1_advance;
         OP_EVENT:  do_event  = s1_advance;
         OP_NONE:   ;
      endcase
   end

   assign cur_row    = key_matrix_ff[sel_row_ff];
   assign sel_row_in = do_select ? s1_value_ff[ROW_BITS-1:0] : sel_row_ff;

   // Clear on press, set on release; shift follows when the character needs it.
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         row_type mask;
         mask = '0;
         if (loc.row == ROW_BITS'(r)) begin
            mask[loc.col] = 1'b1;
         end
         if (loc.shift && (SHIFT_ROW == ROW_BITS'(r))) begin
            mask[SHIFT_COL] = 1'b1;
         end
         if (!do_event) begin
            key_matrix_in[r] = key_matrix_ff[r];
         end else if (s1_key_down_ff) begin
            key_matrix_in[r] = key_matrix_ff[r] & ~mask;
         end else begin
            key_matrix_in[r] = key_matrix_ff[r] | mask;
         end
      end
   end

   assign rsp_valid_in    = do_read || (rsp_valid_ff && rsp_stall);
   assign rsp_row_data_in = do_read ? cur_row : rsp_row_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sel_row_ff   <= '0;
         for (int r = 0; r < NUM_ROWS; r++) begin
            key_matrix_ff[r] <= ROW_IDLE;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_row_ff   <= sel_row_in;
         for (int r = 0; r < NUM_ROWS; r++) begin
            key_matrix_ff[r] <= key_matrix_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff       <= op_type'(req_operation);
         s1_value_ff    <= req_value;
         s1_key_down_ff <= req_key_down;
      end
      rsp_row_data_ff <= rsp_row_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row_data = rsp_row_data_ff;

   `AKM_ASSERT(a_stall_only_when_held,
      !req_stall || (s1_valid_ff && s1_op_ff == OP_READ),
      "request stalled without a waiting read")
   `AKM_ASSERT_NEXT(a_select_loads_row, do_select,
      sel_row_ff == $past(s1_value_ff[ROW_BITS-1:0]), "row select not stored")
   `AKM_ASSERT_NEXT(a_read_loads_rsp, do_read,
      rsp_valid_ff && (rsp_row_data_ff == $past(cur_row)), "read did not load the response")
   `AKM_ASSERT_NEXT(a_shift_press, do_event && loc.shift && s1_key_down_ff,
      !key_matrix_ff[SHIFT_ROW][SHIFT_COL], "shift not pressed with a shifted character")

endmodule
